// ===== rtl/core/cbe_pkg.sv =====
package cbe_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int FRAC_BITS = 16;
	localparam int ONE_FX = 1 << FRAC_BITS;
	localparam int HALF_FX = 1 << (FRAC_BITS - 1);
	localparam int EASE_LIMIT = 4 << FRAC_BITS;

	localparam int IN_DATA_W = 112;
	localparam int OUT_DATA_W = 56;
	localparam int APB_ADDR_W = 4;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_Y1 = 2'd1;
	localparam logic [1:0] REG_Y2 = 2'd2;

	localparam logic [1:0] MODE_LINEAR = 2'd0;
	localparam logic [1:0] MODE_STEP = 2'd1;
	localparam logic [1:0] MODE_BEZIER = 2'd2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef logic signed [19:0] q2_16_t;

endpackage

// ===== rtl/core/cbe_ram.sv =====
module cbe_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output logic [WIDTH-1:0]  rd_data_a,
	output logic [WIDTH-1:0]  rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

// ===== rtl/core/cubic_bezier_easing_interpolator_unit.sv =====
// channel   | direction | handshake          | payload
// s_*       | in        | s_tvalid/s_tready  | s_tdata items, s_tuser command
// m_*       | out       | m_tvalid/m_tready  | m_tdata results, m_tuser saturated
// apb       | in        | psel/penable/pready| curve_mode, curve_y1, curve_y2
//
// one item per cycle when m_tready does not stall the pipeline; an evaluate result passes
// through registered stages (table read, lerp, three multiply stages, ease select, scale, add/saturate)
// a load writes the table at its transaction edge and yields no result
// arst_n clears valid bits and sets the curve registers to their defaults
// each stage advances when empty or when the next one moves, so bubbles fill
// while the output register waits; the table is undefined until loaded
module cubic_bezier_easing_interpolator_unit #(
	parameter int TABLE_DEPTH = cbe_pkg::TABLE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// table_index[5:0], table_word[22:6], alpha[41:23], start_value[73:42],
	// end_value[105:74], zero fill
	input  logic [cbe_pkg::IN_DATA_W-1:0]    s_tdata,
	// command[0]
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// result_value[31:0], eased_progress[51:32], zero fill
	output logic [cbe_pkg::OUT_DATA_W-1:0]   m_tdata,
	// saturated[0]
	output logic                             m_tuser,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [cbe_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	import cbe_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int SC_W = 17 + IDX_W;

	// configuration
	logic [1:0] mode_q;
	q2_16_t     y1_q;
	q2_16_t     y2_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LINEAR;
			y1_q <= '0;
			y2_q <= 20'(ONE_FX);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MODE: mode_q <= pwdata[1:0];
				REG_Y1: y1_q <= pwdata[19:0];
				REG_Y2: y2_q <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MODE: prdata = {30'b0, mode_q};
			REG_Y1: prdata = {{12{y1_q[19]}}, y1_q};
			REG_Y2: prdata = {{12{y2_q[19]}}, y2_q};
			default: prdata = '0;
		endcase
	end

	// stage enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;
	logic in_acc;

	always_comb begin
		en8 = ~v_s8 | m_tready;
		en7 = ~v_s7 | en8;
		en6 = ~v_s6 | en7;
		en5 = ~v_s5 | en6;
		en4 = ~v_s4 | en5;
		en3 = ~v_s3 | en4;
		en2 = ~v_s2 | en3;
		en1 = ~v_s1 | en2;
	end

	assign s_tready = en1;
	assign in_acc = s_tvalid & s_tready;

	// input unpack and index computation
	logic               in_cmd;
	logic [5:0]         in_index;
	logic [16:0]        in_word;
	logic signed [18:0] in_alpha;
	logic [31:0]        in_start;
	logic [31:0]        in_end;
	logic [16:0]        a0;
	logic [SC_W-1:0]    scaled;
	logic [IDX_W-1:0]   lo_idx;
	logic [IDX_W-1:0]   hi_idx;
	logic               tbl_we;

	assign in_cmd = s_tuser;
	assign in_index = s_tdata[5:0];
	assign in_word = s_tdata[22:6];
	assign in_alpha = s_tdata[41:23];
	assign in_start = s_tdata[73:42];
	assign in_end = s_tdata[105:74];

	always_comb begin
		if (in_alpha[18]) begin
			a0 = '0;
		end else if (in_alpha > 19'(ONE_FX)) begin
			a0 = 17'(ONE_FX);
		end else begin
			a0 = in_alpha[16:0];
		end
		scaled = SC_W'(a0) * SC_W'(TABLE_DEPTH - 1);
		lo_idx = scaled[FRAC_BITS +: IDX_W];
		hi_idx = (lo_idx == IDX_W'(TABLE_DEPTH - 1)) ? lo_idx : lo_idx + 1'b1;
	end

	assign tbl_we = in_acc & (in_cmd == CMD_LOAD) & (32'(in_index) < TABLE_DEPTH);

	logic [16:0] tlo;
	logic [16:0] thi;

	cbe_ram #(
		.WIDTH(17),
		.DEPTH(TABLE_DEPTH),
		.ADDR_W(IDX_W)
	) u_table (
		.clk(clk),
		.wr_en(tbl_we),
		.wr_addr(IDX_W'(in_index)),
		.wr_data(in_word),
		.rd_en(en1),
		.rd_addr_a(lo_idx),
		.rd_addr_b(hi_idx),
		.rd_data_a(tlo),
		.rd_data_b(thi)
	);

	// stage 1
	logic [16:0]          a_s1;
	logic [FRAC_BITS-1:0] frac_s1;
	logic [31:0]          start_s1;
	logic [31:0]          end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_acc & (in_cmd == CMD_EVAL);
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			a_s1 <= a0;
			frac_s1 <= scaled[FRAC_BITS-1:0];
			start_s1 <= in_start;
			end_s1 <= in_end;
		end
	end

	// stage 2: lerp between table entries
	logic signed [17:0] t_diff;
	logic signed [34:0] ip_prod;
	logic signed [18:0] t_sum;
	logic [16:0]        t_s2;
	logic [16:0]        a_s2;
	logic signed [32:0] dv_s2;
	logic [31:0]        start_s2;

	always_comb begin
		t_diff = $signed({1'b0, thi}) - $signed({1'b0, tlo});
		ip_prod = 35'(t_diff) * $signed({19'b0, frac_s1}) + 35'(HALF_FX);
		t_sum = $signed({2'b0, tlo}) + ip_prod[34:FRAC_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			t_s2 <= t_sum[16:0];
			a_s2 <= a_s1;
			dv_s2 <= $signed({end_s1[31], end_s1}) - $signed({start_s1[31], start_s1});
			start_s2 <= start_s1;
		end
	end

	// stage 3: (1-t)^2 and t^2
	logic signed [17:0] u_c;
	logic signed [35:0] uu_prod;
	logic [33:0]        tt_prod;
	logic signed [19:0] uu_s3;
	logic [17:0]        tt_s3;
	logic signed [17:0] u_s3;
	logic [16:0]        t_s3;
	logic [16:0]        a_s3;
	logic signed [32:0] dv_s3;
	logic [31:0]        start_s3;

	always_comb begin
		u_c = 18'(ONE_FX) - $signed({1'b0, t_s2});
		uu_prod = 36'(u_c) * 36'(u_c) + 36'(HALF_FX);
		tt_prod = 34'(t_s2) * 34'(t_s2) + 34'(HALF_FX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			uu_s3 <= uu_prod[35:FRAC_BITS];
			tt_s3 <= tt_prod[33:FRAC_BITS];
			u_s3 <= u_c;
			t_s3 <= t_s2;
			a_s3 <= a_s2;
			dv_s3 <= dv_s2;
			start_s3 <= start_s2;
		end
	end

	// stage 4: the three cubic products
	logic signed [37:0] uut_prod;
	logic signed [36:0] ttu_prod;
	logic [34:0]        ttt_prod;
	logic signed [21:0] uut_s4;
	logic signed [20:0] ttu_s4;
	logic [18:0]        ttt_s4;
	logic [16:0]        a_s4;
	logic signed [32:0] dv_s4;
	logic [31:0]        start_s4;

	always_comb begin
		uut_prod = 38'(uu_s3) * $signed({21'b0, t_s3}) + 38'(HALF_FX);
		ttu_prod = $signed({19'b0, tt_s3}) * 37'(u_s3) + 37'(HALF_FX);
		ttt_prod = 35'(tt_s3) * 35'(t_s3) + 35'(HALF_FX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			uut_s4 <= uut_prod[37:FRAC_BITS];
			ttu_s4 <= ttu_prod[36:FRAC_BITS];
			ttt_s4 <= ttt_prod[34:FRAC_BITS];
			a_s4 <= a_s3;
			dv_s4 <= dv_s3;
			start_s4 <= start_s3;
		end
	end

	// stage 5: weight by control points
	logic signed [23:0] uut3;
	logic signed [22:0] ttu3;
	logic signed [43:0] w1_prod;
	logic signed [42:0] w2_prod;
	logic signed [27:0] term1_s5;
	logic signed [26:0] term2_s5;
	logic [18:0]        ttt_s5;
	logic [16:0]        a_s5;
	logic signed [32:0] dv_s5;
	logic [31:0]        start_s5;

	always_comb begin
		uut3 = (24'(uut_s4) <<< 1) + 24'(uut_s4);
		ttu3 = (23'(ttu_s4) <<< 1) + 23'(ttu_s4);
		w1_prod = 44'(uut3) * 44'(y1_q) + 44'(HALF_FX);
		w2_prod = 43'(ttu3) * 43'(y2_q) + 43'(HALF_FX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			term1_s5 <= w1_prod[43:FRAC_BITS];
			term2_s5 <= w2_prod[42:FRAC_BITS];
			ttt_s5 <= ttt_s4;
			a_s5 <= a_s4;
			dv_s5 <= dv_s4;
			start_s5 <= start_s4;
		end
	end

	// stage 6: mode select and eased saturation
	logic signed [29:0] bez_sum;
	logic signed [29:0] ease_c;
	q2_16_t             eased_s6;
	logic               esat_s6;
	logic signed [32:0] dv_s6;
	logic [31:0]        start_s6;

	always_comb begin
		bez_sum = 30'(term1_s5) + 30'(term2_s5) + $signed({11'b0, ttt_s5});
		case (mode_q)
			MODE_STEP: ease_c = (a_s5 == 17'(ONE_FX)) ? 30'(ONE_FX) : '0;
			MODE_BEZIER: ease_c = bez_sum;
			default: ease_c = $signed({13'b0, a_s5});
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			if (ease_c > 30'(EASE_LIMIT)) begin
				eased_s6 <= 20'(EASE_LIMIT);
				esat_s6 <= 1'b1;
			end else if (ease_c < -30'(EASE_LIMIT)) begin
				eased_s6 <= -20'(EASE_LIMIT);
				esat_s6 <= 1'b1;
			end else begin
				eased_s6 <= ease_c[19:0];
				esat_s6 <= 1'b0;
			end
			dv_s6 <= dv_s5;
			start_s6 <= start_s5;
		end
	end

	// stage 7: scale the span
	logic signed [52:0] sc_prod;
	logic signed [36:0] prod_s7;
	q2_16_t             eased_s7;
	logic               esat_s7;
	logic [31:0]        start_s7;

	assign sc_prod = 53'(dv_s6) * 53'(eased_s6) + 53'(HALF_FX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en7) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			prod_s7 <= sc_prod[52:FRAC_BITS];
			eased_s7 <= eased_s6;
			esat_s7 <= esat_s6;
			start_s7 <= start_s6;
		end
	end

	// stage 8: offset, saturate, output register
	logic signed [37:0] res_c;
	logic [31:0]        result_s8;
	q2_16_t             eased_s8;
	logic               sat_s8;

	assign res_c = 38'($signed(start_s7)) + 38'(prod_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en8) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en8) begin
			eased_s8 <= eased_s7;
			if (res_c > 38'sh7FFF_FFFF) begin
				result_s8 <= 32'h7FFF_FFFF;
				sat_s8 <= 1'b1;
			end else if (res_c < -38'sh8000_0000) begin
				result_s8 <= 32'h8000_0000;
				sat_s8 <= 1'b1;
			end else begin
				result_s8 <= res_c[31:0];
				sat_s8 <= esat_s7;
			end
		end
	end

	assign m_tvalid = v_s8;
	assign m_tdata = {4'b0, eased_s8, result_s8};
	assign m_tuser = sat_s8;

endmodule
